// ----- rtl/core/phsr_pkg.sv -----
// Shared widths, types, sine table builder and fixed-point helpers for the phaser.
package phsr_pkg;

	// Sizes of the block
	localparam int STAGES      = 6;
	localparam int SAMPLE_W    = 16;
	localparam int STATE_W     = 24;
	localparam int PHASE_W     = 24;
	localparam int TAB_N       = 1024;
	localparam int TAB_AW      = $clog2(TAB_N);
	localparam int TAB_EW      = 16;

	// Configuration port
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 23;

	// Coefficient and product widths
	localparam int COEF_W      = 17;
	localparam int PROD_W      = COEF_W + 1 + STATE_W;
	localparam int ACC_W       = 32;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_MIN     = 3'd0,
		REG_DELAY_MAX     = 3'd1,
		REG_LFO_INCREMENT = 3'd2,
		REG_FEEDBACK_GAIN = 3'd3,
		REG_MIX_DEPTH     = 3'd4
	} phsr_reg_t;

	// Sample handed from one allpass cell to the next
	typedef struct packed {
		logic                      vld;
		logic signed [STATE_W-1:0] smp;
	} phsr_tok_t;

	// Sine table
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_SCALE  = 64'd32767;
	localparam logic [63:0] TAB_N64     = 64'(TAB_N);
	localparam logic [63:0] SIN_DIVS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef logic signed [TAB_EW-1:0] sine_rom_t [TAB_N];

	// One table entry: quarter-wave fold, Q30 Taylor series, round at scale 32767
	function automatic logic signed [TAB_EW-1:0] sine_entry(input int unsigned k);
		logic [63:0] m;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		logic        neg;
		m   = 64'(k) << 2;
		neg = 1'b0;
		if (m <= TAB_N64) begin
			r = m;
		end else if (m <= 2 * TAB_N64) begin
			r = 2 * TAB_N64 - m;
		end else if (m <= 3 * TAB_N64) begin
			r   = m - 2 * TAB_N64;
			neg = 1'b1;
		end else begin
			r   = 4 * TAB_N64 - m;
			neg = 1'b1;
		end
		x  = (HALF_PI_Q30 * r) / TAB_N64;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			t = Q30_ONE - ((x2 * t) >> 30) / SIN_DIVS[i];
		end
		s = (x * t) >> 30;
		e = (s * SINE_SCALE + (64'd1 << 29)) >> 30;
		return neg ? -TAB_EW'(e) : TAB_EW'(e);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k < TAB_N; k++) begin
			rom[k] = sine_entry(k);
		end
		return rom;
	endfunction

	// Round a coefficient product by 2^16, half toward plus infinity
	function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] w;
		w = p + PROD_W'(signed'(33'sd32768));
		return ACC_W'(w >>> 16);
	endfunction

	// Clamp to the state width
	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'((33'sd1 <<< (STATE_W - 1)) - 33'sd1));
		lo = -hi - ACC_W'(signed'(33'sd1));
		if (v > hi) return STATE_W'(hi);
		if (v < lo) return STATE_W'(lo);
		return STATE_W'(v);
	endfunction

	// Clamp to the sample width
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'((33'sd1 <<< (SAMPLE_W - 1)) - 33'sd1));
		lo = -hi - ACC_W'(signed'(33'sd1));
		if (v > hi) return SAMPLE_W'(hi);
		if (v < lo) return SAMPLE_W'(lo);
		return SAMPLE_W'(v);
	endfunction

endpackage

// ----- rtl/core/phsr_in_if.sv -----
// Input sample channel: valid, ready and one dry sample.
interface phsr_in_if;
	import phsr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/core/phsr_out_if.sv -----
// Output sample channel: valid, ready and one processed sample.
interface phsr_out_if;
	import phsr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/core/phsr_cfg_if.sv -----
// Configuration write channel: valid, ready, register index and write data.
interface phsr_cfg_if;
	import phsr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/phsr_coef.sv -----
// LFO phase, sine table, sweep of the delay and the serial divider for the allpass coefficient.
module phsr_coef (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [15:0]                   delay_min,
	input  logic [15:0]                   delay_max,
	input  logic [phsr_pkg::CFG_DATA_W-1:0] lfo_increment,
	output logic                          done,
	output logic [phsr_pkg::COEF_W-1:0]   a1
);
	import phsr_pkg::*;

	localparam int DIV_STEPS = COEF_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam sine_rom_t SINE_ROM = build_sine_rom();

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_MUL  = 4'b0010,
		C_SWP  = 4'b0100,
		C_DIV  = 4'b1000
	} coef_state_t;

	coef_state_t              state_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     done_q;
	logic signed [TAB_EW-1:0] ent_s1;
	logic [32:0]              pa_s2;
	logic [31:0]              pb_s2;
	logic [COEF_W-1:0]        den_q;
	logic [COEF_W-1:0]        num_q;
	logic [COEF_W-1:0]        rem_q;
	logic [COEF_W-1:0]        quo_q;
	logic [COEF_W-1:0]        a1_q;

	logic [15:0]              u;
	logic [COEF_W-1:0]        u_inv;
	logic [33:0]              sweep_sum;
	logic [15:0]              d;
	logic [COEF_W-1:0]        d_inv;
	logic [COEF_W-1:0]        den_n;
	logic [32:0]              num_n;
	logic [COEF_W:0]          trial;
	logic                     qbit;
	logic                     start_ok;

	// Sweep point from the table entry, then the delay between the bounds
	assign u         = {~ent_s1[TAB_EW-1], ent_s1[TAB_EW-2:0]};
	assign u_inv     = 17'd65536 - {1'b0, u};
	assign sweep_sum = {1'b0, pa_s2} + {2'b00, pb_s2};
	assign d         = sweep_sum[31:16];
	assign d_inv     = 17'd65536 - {1'b0, d};
	assign den_n     = 17'd65536 + {1'b0, d};
	assign num_n     = ({16'd0, d_inv} << 16) + {17'd0, den_n[COEF_W-1:1]};

	// One restoring step of the divider
	assign trial = {rem_q, num_q[COEF_W-1]};
	assign qbit  = trial >= {1'b0, den_q};
	assign start_ok = start && (state_q == C_IDLE);

	// Sequence the coefficient computation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start_ok) begin
						phase_q <= phase_q + PHASE_W'(lfo_increment);
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					state_q <= C_SWP;
				end
				C_SWP: begin
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
					state_q <= C_DIV;
				end
				C_DIV: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Table read, sweep products and divider datapath
	always_ff @(posedge clk) begin
		if (start_ok) begin
			ent_s1 <= SINE_ROM[phase_q[PHASE_W-1 -: TAB_AW]];
		end
		if (state_q == C_MUL) begin
			pa_s2 <= delay_min * u_inv;
			pb_s2 <= delay_max * u;
		end
		if (state_q == C_SWP) begin
			den_q <= den_n;
			rem_q <= {1'b0, num_n[32:COEF_W]};
			num_q <= num_n[COEF_W-1:0];
		end
		if (state_q == C_DIV) begin
			rem_q <= qbit ? COEF_W'(trial - {1'b0, den_q}) : trial[COEF_W-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[COEF_W-2:0], qbit};
			if (cnt_q == '0) begin
				a1_q <= {quo_q[COEF_W-2:0], qbit};
			end
		end
	end

	assign done = done_q;
	assign a1   = a1_q;

endmodule

// ----- rtl/core/phsr_cell.sv -----
// One first-order allpass cell: holds its delay element and passes its output on.
module phsr_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [phsr_pkg::COEF_W-1:0] a1,
	input  phsr_pkg::phsr_tok_t         tok_in,
	output phsr_pkg::phsr_tok_t         tok_out
);
	import phsr_pkg::*;

	logic                       v_s1;
	logic                       v_s2;
	logic                       v_s3;
	logic signed [STATE_W-1:0]  mem_q;
	logic signed [STATE_W-1:0]  x_s1;
	logic signed [PROD_W-1:0]   p1_s1;
	logic signed [STATE_W-1:0]  y_s2;
	logic signed [PROD_W-1:0]   p2_s3;
	logic signed [COEF_W:0]     a1s;

	assign a1s = signed'({1'b0, a1});

	// Step flags and the delay element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			mem_q <= '0;
		end else begin
			v_s1 <= tok_in.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			// update the delay element from the feedforward product
			if (v_s3) begin
				mem_q <= sat_state(rnd16(p2_s3) + ACC_W'(x_s1));
			end
		end
	end

	// Product of the input, cell output, product of the output
	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			x_s1  <= tok_in.smp;
			p1_s1 <= a1s * tok_in.smp;
		end
		if (v_s1) begin
			y_s2 <= sat_state(ACC_W'(mem_q) - rnd16(p1_s1));
		end
		if (v_s2) begin
			p2_s3 <= a1s * y_s2;
		end
	end

	assign tok_out.vld = v_s2;
	assign tok_out.smp = y_s2;

endmodule

// ----- rtl/core/six_stage_allpass_phaser.sv -----
// Top level of the six-stage allpass phaser: registers, feedback, cell chain and dry/wet mix.
//
// One dry sample in, one saturated dry-plus-wet sample out. The input stays closed from
// acceptance until the result is in the output register. The coefficient comes first: a
// table read, the sweep products, loading the divider and a 17-step restoring divider that
// forms a1 one quotient bit per cycle. Then comes the cell chain, where each of the six
// allpass cells registers its input product and then its output before handing the output
// to the next cell; the mix product and the output register are loaded last. The output
// register frees the input side, so a new sample is taken while the previous result still
// waits. Configuration writes are always taken and should only be issued while no sample
// is in flight. No clearing pass runs after reset.
module six_stage_allpass_phaser (
	input logic        clk,
	input logic        arst_n,
	phsr_in_if.sink    audio,
	phsr_out_if.source result,
	phsr_cfg_if.sink   cfg
);
	import phsr_pkg::*;

	localparam int FB_W = STATE_W + 16;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_COEF  = 4'b0010,
		S_CHAIN = 4'b0100,
		S_MIX   = 4'b1000
	} top_state_t;

	top_state_t                 state_q;
	logic [15:0]                dmin_q;
	logic [15:0]                dmax_q;
	logic [CFG_DATA_W-1:0]      inc_q;
	logic [14:0]                fg_q;
	logic [16:0]                depth_q;
	logic signed [STATE_W-1:0]  lco_q;
	logic                       res_valid_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic signed [SAMPLE_W-1:0] dry_q;
	logic signed [FB_W-1:0]     fb_prod_s1;
	logic signed [PROD_W-1:0]   mix_prod_s1;

	logic                       accept;
	logic                       coef_done;
	logic [COEF_W-1:0]          a1;
	logic [16:0]                depth_sat;
	logic signed [FB_W-1:0]     fb_w;
	logic signed [ACC_W-1:0]    fb_rnd;
	logic signed [STATE_W-1:0]  x0;
	logic                       out_free;
	phsr_tok_t                  tok [STAGES+1];

	assign accept      = audio.valid && audio.ready;
	assign audio.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign out_free    = !res_valid_q || result.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q  <= 16'd1202;
			dmax_q  <= 16'd4369;
			inc_q   <= 23'd175;
			fg_q    <= 15'd22938;
			depth_q <= 17'd65536;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DELAY_MIN:     dmin_q  <= cfg.data[15:0];
				REG_DELAY_MAX:     dmax_q  <= cfg.data[15:0];
				REG_LFO_INCREMENT: inc_q   <= cfg.data;
				REG_FEEDBACK_GAIN: fg_q    <= cfg.data[14:0];
				REG_MIX_DEPTH:     depth_q <= cfg.data[16:0];
				default: begin
				end
			endcase
		end
	end

	// Coefficient for this item
	phsr_coef u_coef (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (accept),
		.delay_min     (dmin_q),
		.delay_max     (dmax_q),
		.lfo_increment (inc_q),
		.done          (coef_done),
		.a1            (a1)
	);

	// Chain input: dry sample plus rounded feedback, clamped
	assign fb_w   = fb_prod_s1 + FB_W'(signed'(33'sd16384));
	assign fb_rnd = ACC_W'(fb_w >>> 15);
	assign x0     = sat_state(ACC_W'(dry_q) + fb_rnd);

	assign tok[0].vld = coef_done && (state_q == S_COEF);
	assign tok[0].smp = x0;

	// Row of allpass cells
	for (genvar g = 0; g < STAGES; g++) begin : g_cell
		phsr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.a1      (a1),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	assign depth_sat = (depth_q > 17'd65536) ? 17'd65536 : depth_q;

	// Item sequencing and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lco_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// load the output register, or drop the item the sink has taken
			if ((state_q == S_MIX) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_COEF;
					end
				end
				S_COEF: begin
					if (coef_done) begin
						state_q <= S_CHAIN;
					end
				end
				S_CHAIN: begin
					if (tok[STAGES].vld) begin
						lco_q   <= tok[STAGES].smp;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Sample datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dry_q <= audio.sample_in;
		end
		if (state_q == S_COEF) begin
			fb_prod_s1 <= lco_q * signed'({1'b0, fg_q});
		end
		if ((state_q == S_CHAIN) && tok[STAGES].vld) begin
			mix_prod_s1 <= tok[STAGES].smp * signed'({1'b0, depth_sat});
		end
		if ((state_q == S_MIX) && out_free) begin
			res_q <= sat_sample(ACC_W'(dry_q) + rnd16(mix_prod_s1));
		end
	end

	assign result.valid      = res_valid_q;
	assign result.sample_out = res_q;

	// A new item closes the input until its result is in the output register
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !audio.ready)
		else $error("input accepted again while an item is in flight");

	// The coefficient only finishes while the item waits for it
	a_coef_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		coef_done |-> (state_q == S_COEF))
		else $error("coefficient finished outside its wait state");

	// The last cell only delivers while the chain is running
	a_chain_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		tok[STAGES].vld |-> (state_q == S_CHAIN))
		else $error("chain output outside the chain state");

	// A result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.sample_out)))
		else $error("pending result overwritten");

endmodule

// ----- tb/sv/six_stage_allpass_phaser_test.sv -----
// Self-checking testbench for the six-stage allpass phaser with its own fixed-point predictor.
`timescale 1ns / 100ps

module six_stage_allpass_phaser_test;
	import phsr_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 60;
	localparam int          CFG_SETTLE   = 4;
	localparam int          Q30_SHIFT    = 30;
	localparam longint      SINE_AMPL    = 32767;
	localparam longint      UNITY_Q16    = 65536;
	localparam longint unsigned HALF_PI_Q30_TB = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

	// Register indexes that the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	phsr_in_if  in_ch ();
	phsr_out_if out_ch ();
	phsr_cfg_if cfg_ch ();

	six_stage_allpass_phaser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.audio  (in_ch),
		.result (out_ch),
		.cfg    (cfg_ch)
	);

	// Predictor copy of the registers and state
	logic [15:0]         delay_lo;
	logic [15:0]         delay_hi;
	logic [22:0]         lfo_step;
	logic [14:0]         fb_gain;
	logic [16:0]         wet_depth;
	logic [PHASE_W-1:0]  lfo_pos;
	longint              chain_fb;
	longint              cell_mem [STAGES];
	int                  sine_lut [TAB_N];

	logic signed [SAMPLE_W-1:0] pending_out [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned stall_left     = 0;

	always #4 clk = ~clk;

	// Sine entry k: quarter-wave fold, Q30 Taylor series, rounded at scale 32767
	function automatic int sine_q15(input int unsigned k);
		longint unsigned m, r, x, x2, t, s, e;
		bit neg;
		m   = longint'(k) * 4;
		neg = 1'b0;
		if (m <= TAB_N) begin
			r = m;
		end else if (m <= 2 * TAB_N) begin
			r = 2 * TAB_N - m;
		end else if (m <= 3 * TAB_N) begin
			r   = m - 2 * TAB_N;
			neg = 1'b1;
		end else begin
			r   = 4 * TAB_N - m;
			neg = 1'b1;
		end
		x  = (HALF_PI_Q30_TB * r) / TAB_N;
		x2 = (x * x) >> Q30_SHIFT;
		t  = 64'd1 << Q30_SHIFT;
		for (int i = 0; i < 6; i++) begin
			t = (64'd1 << Q30_SHIFT) - ((x2 * t) >> Q30_SHIFT) / TAYLOR_DIV[i];
		end
		s = (x * t) >> Q30_SHIFT;
		e = (s * SINE_AMPL + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
		return neg ? -int'(e) : int'(e);
	endfunction

	// Shift right by s, rounding half toward plus infinity
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// Advance the LFO and the allpass chain by one sample, return the mixed output
	function automatic logic signed [SAMPLE_W-1:0] phaser_output(
			input logic signed [SAMPLE_W-1:0] dry_smp);
		longint dry, idx, u, d, a1, depth, x, y;
		dry = dry_smp;
		idx = (longint'(lfo_pos) * TAB_N) >>> PHASE_W;
		u   = sine_lut[idx] + 32768;
		lfo_pos = lfo_pos + lfo_step;
		d  = (longint'(delay_lo) * (UNITY_Q16 - u) + longint'(delay_hi) * u) >>> 16;
		a1 = (((UNITY_Q16 - d) <<< 16) + ((UNITY_Q16 + d) >>> 1)) / (UNITY_Q16 + d);
		x  = clamp(dry + round_shift(chain_fb * longint'(fb_gain), 15), STATE_W);
		for (int i = STAGES - 1; i >= 0; i--) begin
			y = clamp(cell_mem[i] - round_shift(a1 * x, 16), STATE_W);
			cell_mem[i] = clamp(round_shift(a1 * y, 16) + x, STATE_W);
			x = y;
		end
		chain_fb = x;
		depth = (longint'(wet_depth) > UNITY_Q16) ? UNITY_Q16 : longint'(wet_depth);
		return SAMPLE_W'(clamp(dry + round_shift(x * depth, 16), SAMPLE_W));
	endfunction

	// Offer one sample, wait for the handshake and queue its expected output
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid     = 1'b1;
		in_ch.sample_in = smp;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_out.push_back(phaser_output(smp));
		@(negedge clk);
	endtask

	// Write one register once the block has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		in_ch.valid = 1'b0;
		wait (pending_out.size() == 0);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_DELAY_MIN:     delay_lo  = val[15:0];
			REG_DELAY_MAX:     delay_hi  = val[15:0];
			REG_LFO_INCREMENT: lfo_step  = val[22:0];
			REG_FEEDBACK_GAIN: fb_gain   = val[14:0];
			REG_MIX_DEPTH:     wet_depth = val[16:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(9))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2, 3, 4: return SAMPLE_W'(int'($urandom_range(511)) - 256);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_DATA_W-1:0] top);
		case ($urandom_range(3))
			0:       return '0;
			1:       return top;
			default: return CFG_DATA_W'($urandom());
		endcase
	endfunction

	task automatic random_config();
		write_reg(REG_DELAY_MIN, pick_value(23'h00FFFF));
		write_reg(REG_DELAY_MAX, pick_value(23'h00FFFF));
		if ($urandom_range(1))
			write_reg(REG_LFO_INCREMENT, pick_value(23'h7FFFFF));
		else
			write_reg(REG_LFO_INCREMENT, CFG_DATA_W'($urandom_range(4095)));
		write_reg(REG_FEEDBACK_GAIN, pick_value(23'h007FFF));
		write_reg(REG_MIX_DEPTH, $urandom_range(1) ? pick_value(23'h01FFFF)
			: CFG_DATA_W'($urandom_range(65536)));
	endtask

	// Reset settings with full-scale and small samples
	task automatic test_reset_defaults();
		send_sample(16'sd0);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		send_sample(SMP_MAX);
	endtask

	// Ignored indexes, excess data bits, reversed bounds, depth above unity, saturation
	task automatic test_special_cases();
		write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom()));
		write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom()));
		write_reg(REG_DELAY_MIN, 23'h7FEA60);
		write_reg(REG_DELAY_MAX, 23'h5501F4);
		write_reg(REG_LFO_INCREMENT, 23'h7FFFFF);
		write_reg(REG_FEEDBACK_GAIN, 23'h7FFFFF);
		write_reg(REG_MIX_DEPTH, 23'h7FFFFF);
		for (int i = 0; i < 10; i++) begin
			send_sample(i[0] ? SMP_MIN : SMP_MAX);
		end
		// Drive the upper delay bound to its top and every other register to its low end
		write_reg(REG_DELAY_MIN, '0);
		write_reg(REG_DELAY_MAX, 23'h00FFFF);
		write_reg(REG_LFO_INCREMENT, '0);
		write_reg(REG_FEEDBACK_GAIN, '0);
		write_reg(REG_MIX_DEPTH, '0);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(16'sd0);
		send_sample(16'sh1234);
	endtask

	// Random samples under each idling pattern, two settings per pattern
	task automatic test_idle_patterns();
		int unsigned send_pct [4];
		int unsigned recv_pct [4];
		send_pct = '{0, 69, 0, 11};
		recv_pct = '{0, 0, 69, 11};
		for (int p = 0; p < 4; p++) begin
			for (int c = 0; c < 2; c++) begin
				in_ch.valid = 1'b0;
				random_config();
				send_idle_pct  = send_pct[p];
				recv_stall_pct = recv_pct[p];
				for (int n = 0; n < 50; n++) begin
					send_sample(random_sample());
				end
			end
		end
	endtask

	// Hold the output off for a long stretch so the input side stalls
	task automatic test_backpressure();
		in_ch.valid = 1'b0;
		random_config();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		stall_left     = 300;
		for (int n = 0; n < 12; n++) begin
			send_sample(random_sample());
		end
	endtask

	// Drive output ready: a counted hold-off first, random stalls otherwise
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else begin
				out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare each output item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_out.size() == 0) begin
				$error("sample_out: no item expected, got %0d", out_ch.sample_out);
				mismatch_count++;
			end else if (out_ch.sample_out !== pending_out[0]) begin
				$error("sample_out: expected %0d, got %0d", pending_out[0], out_ch.sample_out);
				mismatch_count++;
				void'(pending_out.pop_front());
			end else begin
				void'(pending_out.pop_front());
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("six_stage_allpass_phaser_test NOT OK");
			$finish;
		end
	end

	initial begin
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		for (int k = 0; k < TAB_N; k++) begin
			sine_lut[k] = sine_q15(k);
		end
		delay_lo  = 16'd1202;
		delay_hi  = 16'd4369;
		lfo_step  = 23'd175;
		fb_gain   = 15'd22938;
		wet_depth = 17'd65536;
		lfo_pos   = '0;
		chain_fb  = 0;
		foreach (cell_mem[i]) cell_mem[i] = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_special_cases();
		test_idle_patterns();
		test_backpressure();

		// Drain the block and let it settle
		in_ch.valid = 1'b0;
		wait (pending_out.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_out.size() == 0) begin
			$display("six_stage_allpass_phaser_test OK");
		end else begin
			$display("six_stage_allpass_phaser_test NOT OK");
		end
		$finish;
	end

endmodule
